// File: hw/rtl/dss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the shortest-seek-first disk scheduler.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int MAX_REQUESTS_DEF  = 64;
    localparam int POSITION_BITS_DEF = 16;

    localparam int FIELD_W = 16;   // served_position, seek_distance
    localparam int SUM_W   = 23;   // internal running seek sum
    localparam int TOTAL_W = 22;   // total_seek result field

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD_RD,
        ST_HEAD_LD,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // Control for the nearest-request compare unit
    typedef struct packed {
        logic clear;   // start a new pick
        logic valid;   // candidate on the compare inputs this cycle
    } cmp_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/dss_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dss_store
// Request memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dss_store #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/dss_nearest.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dss_nearest
// Shared distance and compare unit: one candidate per cycle, keeps the best.
// ----------------------------------------------------------------------------
module dss_nearest #(
    parameter int POS_W = 16,
    parameter int IDX_W = 6
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dss_pkg::cmp_ctl_t    ctl,
    input  wire logic [IDX_W-1:0]     cand_idx,
    input  wire logic [POS_W-1:0]     cand_pos,
    input  wire logic [POS_W-1:0]     head,
    input  wire logic                 skip,
    output logic      [IDX_W-1:0]     best_idx,
    output logic      [POS_W-1:0]     best_pos,
    output logic      [POS_W-1:0]     best_dist
);

    import dss_pkg::*;

    logic             found_reg;
    logic [POS_W-1:0] cand_dist;
    logic             take;

    assign cand_dist = (head >= cand_pos) ? (head - cand_pos) : (cand_pos - head);
    // strict less-than: an earlier entry wins a tie
    assign take = ctl.valid && !skip && (!found_reg || (cand_dist < best_dist));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctl.clear && take)
        begin
            best_dist <= cand_dist;
            best_idx  <= cand_idx;
            best_pos  <= cand_pos;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/disk_seek_sstf_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// disk_seek_sstf_scheduler
// Shortest-seek-time-first scheduler: load a batch of positions, then serve
// them nearest-first from the first loaded position.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  request   start / busy            request_position, last_request
//  result    result_valid (strobe)   served_position, seek_distance,
//                                    total_seek, final_step, overflow_dropped
//
//  A request beat is taken when start is high and busy is low. The beat
//  marked last starts the run: the start head is read from the first entry
//  and loaded, then each of the n picks reads every stored entry in turn
//  through the single read port of the request memory and the shared
//  compare unit, then passes a drain and an emit state. Each result beat
//  shows the cycle after its emit; busy stays high through the last emit.
//  Reset clears all control state; the service mark of each entry lives in
//  the request memory and is cleared as the entry loads, so no clearing pass
//  is needed.
//  The receiver cannot stall: each result beat shows for exactly one cycle.
// ----------------------------------------------------------------------------
module disk_seek_sstf_scheduler #(
    parameter int MAX_REQUESTS  = dss_pkg::MAX_REQUESTS_DEF,
    parameter int POSITION_BITS = dss_pkg::POSITION_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [dss_pkg::FIELD_W-1:0]  request_position,
    input  wire logic                         last_request,
    output logic                              result_valid,
    output logic      [dss_pkg::FIELD_W-1:0]  served_position,
    output logic      [dss_pkg::FIELD_W-1:0]  seek_distance,
    output logic      [dss_pkg::TOTAL_W-1:0]  total_seek,
    output logic                              final_step,
    output logic                              overflow_dropped
);

    import dss_pkg::*;

    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int IDX_W = $clog2(MAX_REQUESTS);
    localparam int POS_W = POSITION_BITS;

    // sequencer
    state_t state_reg, state_next;

    // batch control
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        scan_reg, scan_next;
    logic [CNT_W-1:0]        pick_reg, pick_next;
    logic                    ovf_reg, ovf_next;
    logic [POS_W-1:0]        head_reg, head_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;

    // compare pipeline (lines up with the registered memory read)
    logic                    pipe_valid_reg, pipe_valid_next;
    logic [IDX_W-1:0]        pipe_idx_reg, pipe_idx_next;

    // result beat
    logic                    res_valid_reg, res_valid_next;
    logic [FIELD_W-1:0]      res_pos_reg, res_pos_next;
    logic [FIELD_W-1:0]      res_dist_reg, res_dist_next;
    logic [TOTAL_W-1:0]      res_total_reg, res_total_next;
    logic                    res_final_reg, res_final_next;
    logic                    res_ovf_reg, res_ovf_next;

    // memory and compare unit hookup; each word is {served mark, position}
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [POS_W:0]          wr_data;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [POS_W:0]          rd_data;
    logic [POS_W-1:0]        pos_in;
    cmp_ctl_t                cmp_ctl;
    logic [IDX_W-1:0]        best_idx;
    logic [POS_W-1:0]        best_pos;
    logic [POS_W-1:0]        best_dist;

    logic                    accept;
    logic                    has_room;
    logic [CNT_W-1:0]        last_idx;
    logic [SUM_W-1:0]        sum_step;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign has_room = (count_reg < CNT_W'(MAX_REQUESTS));
    assign pos_in   = POS_W'(request_position);
    assign last_idx = n_reg - CNT_W'(1);
    assign sum_step = sum_reg + SUM_W'(best_dist);

    dss_store #(
        .DEPTH  (MAX_REQUESTS),
        .WIDTH  (POS_W + 1),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dss_nearest #(
        .POS_W (POS_W),
        .IDX_W (IDX_W)
    ) u_nearest (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (cmp_ctl),
        .cand_idx  (pipe_idx_reg),
        .cand_pos  (rd_data[POS_W-1:0]),
        .head      (head_reg),
        .skip      (rd_data[POS_W]),
        .best_idx  (best_idx),
        .best_pos  (best_pos),
        .best_dist (best_dist)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_request)
                begin
                    state_next = ST_HEAD_RD;
                end
            end
            ST_HEAD_RD: state_next = ST_HEAD_LD;
            ST_HEAD_LD: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:   state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (pick_reg == last_idx)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath and control outputs
    always_comb
    begin
        count_next      = count_reg;
        n_next          = n_reg;
        scan_next       = scan_reg;
        pick_next       = pick_reg;
        ovf_next        = ovf_reg;
        head_next       = head_reg;
        sum_next        = sum_reg;
        pipe_valid_next = 1'b0;
        pipe_idx_next   = pipe_idx_reg;
        res_valid_next  = 1'b0;
        res_pos_next    = res_pos_reg;
        res_dist_next   = res_dist_reg;
        res_total_next  = res_total_reg;
        res_final_next  = res_final_reg;
        res_ovf_next    = res_ovf_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[IDX_W-1:0];
        wr_data         = {1'b0, pos_in};
        rd_en           = 1'b0;
        rd_addr         = scan_reg[IDX_W-1:0];
        cmp_ctl.clear   = 1'b0;
        cmp_ctl.valid   = pipe_valid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // store the beat with its mark clear while room is left,
                    // else drop and flag it
                    if (has_room)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_request)
                    begin
                        n_next   = has_room ? (count_reg + CNT_W'(1)) : count_reg;
                        sum_next = '0;
                    end
                end
            end
            ST_HEAD_RD:
            begin
                // first loaded entry is the starting head
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            ST_HEAD_LD:
            begin
                head_next     = rd_data[POS_W-1:0];
                scan_next     = '0;
                pick_next     = '0;
                cmp_ctl.clear = 1'b1;
            end
            ST_SCAN:
            begin
                // issue one read a cycle; compare lands in the cycle after the read
                rd_en           = 1'b1;
                pipe_valid_next = 1'b1;
                pipe_idx_next   = scan_reg[IDX_W-1:0];
                scan_next       = scan_reg + CNT_W'(1);
            end
            ST_DRAIN:
            begin
                // last candidate is compared this cycle
            end
            ST_EMIT:
            begin
                // mark the winner served in its memory word
                wr_en          = 1'b1;
                wr_addr        = best_idx;
                wr_data        = {1'b1, best_pos};
                head_next      = best_pos;
                sum_next       = sum_step;
                res_valid_next = 1'b1;
                res_pos_next   = FIELD_W'(best_pos);
                res_dist_next  = FIELD_W'(best_dist);
                res_total_next = sum_step[TOTAL_W-1:0];
                res_final_next = (pick_reg == last_idx);
                res_ovf_next   = ovf_reg;
                pick_next      = pick_reg + CNT_W'(1);
                scan_next      = '0;
                cmp_ctl.clear  = 1'b1;
                if (pick_reg == last_idx)
                begin
                    // drop batch state, keep the head where it ended
                    count_next = '0;
                    sum_next   = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            n_reg          <= '0;
            scan_reg       <= '0;
            pick_reg       <= '0;
            ovf_reg        <= 1'b0;
            head_reg       <= '0;
            sum_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            n_reg          <= n_next;
            scan_reg       <= scan_next;
            pick_reg       <= pick_next;
            ovf_reg        <= ovf_next;
            head_reg       <= head_next;
            sum_reg        <= sum_next;
            pipe_valid_reg <= pipe_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        pipe_idx_reg  <= pipe_idx_next;
        res_pos_reg   <= res_pos_next;
        res_dist_reg  <= res_dist_next;
        res_total_reg <= res_total_next;
        res_final_reg <= res_final_next;
        res_ovf_reg   <= res_ovf_next;
    end

    assign result_valid     = res_valid_reg;
    assign served_position  = res_pos_reg;
    assign seek_distance    = res_dist_reg;
    assign total_seek       = res_total_reg;
    assign final_step       = res_final_reg;
    assign overflow_dropped = res_ovf_reg;

endmodule
`default_nettype wire
